// ===== design/c3cb_pkg.sv =====
// Shared constants and types of the 3x3 convolution block.
package c3cb_pkg;

  // Pixel and window geometry
  localparam int PIX_W     = 8;
  localparam int NUM_TAPS  = 9;
  localparam int NUM_CELLS = 2;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_TAP_BITS   = 5;

  // Register field widths
  localparam int SHIFT_W  = 4;
  localparam int OFFSET_W = 17;
  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 13;

  // Configuration port
  localparam int APB_DW = 64;
  localparam int APB_AW = 6;

  // Reset values of the configuration registers
  localparam int RST_TAPS [NUM_TAPS] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
  localparam logic [SHIFT_W-1:0]         RST_SCALE_SHIFT  = 4'd4;
  localparam logic signed [OFFSET_W-1:0] RST_SUM_OFFSET   = 17'sd0;
  localparam logic [WIDTH_W-1:0]         RST_FRAME_WIDTH  = 12'd2048;
  localparam logic [HEIGHT_W-1:0]        RST_FRAME_HEIGHT = 13'd4096;

  // One window column, index 0 is the top row
  typedef logic [2:0][PIX_W-1:0] col_t;
  // Selected 3x3 window, [column][row], column 0 is the left one
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

endpackage

// ===== design/c3cb_in_if.sv =====
// Input channel: pixel or flush request with valid/ready handshake.
interface c3cb_in_if;
  logic                       valid;
  logic                       ready;
  logic                       flush;
  logic [c3cb_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, flush, pixel_in, input ready);
  modport sink (input valid, flush, pixel_in, output ready);
endinterface

// ===== design/c3cb_out_if.sv =====
// Output channel: filtered pixel with frame end flag, valid/ready handshake.
interface c3cb_out_if;
  logic                       valid;
  logic                       ready;
  logic [c3cb_pkg::PIX_W-1:0] pixel_out;
  logic                       frame_end;

  modport source (output valid, pixel_out, frame_end, input ready);
  modport sink (input valid, pixel_out, frame_end, output ready);
endinterface

// ===== design/conv3x3_clamped_border.sv =====
// Top level: 3x3 convolution over a raster pixel stream with replicated borders.
//
//  channel   | dir | handshake          | payload
//  in_ch     | in  | valid/ready        | flush, pixel_in
//  out_ch    | out | valid/ready        | pixel_out, frame_end
//  apb       | in  | psel/penable/pwrite| paddr, pwdata -> prdata, pready=1
//
// One request per cycle while the output is not stalled; the result of the request that
// completes a window passes line buffer read, window cells, add tree and output reg.
// Line buffer is a single-port-write/single-port-read memory of MAX_WIDTH pixel pairs.
// Reset clears counters and valids and loads register defaults; line memory needs no clearing pass.
// Output stall fills the pipeline bubbles first; input stalls only when all stages hold.
module conv3x3_clamped_border #(
  parameter int MAX_WIDTH  = c3cb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = c3cb_pkg::DEF_MAX_HEIGHT,
  parameter int TAP_BITS   = c3cb_pkg::DEF_TAP_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  c3cb_in_if.sink                       in_ch,
  c3cb_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [c3cb_pkg::APB_AW-1:0]   paddr,
  input  logic [c3cb_pkg::APB_DW-1:0]   pwdata,
  output logic [c3cb_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int KW = c3cb_pkg::NUM_TAPS * TAP_BITS;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int PW = c3cb_pkg::PIX_W;

  typedef enum logic [2:0] {
    REG_KERNEL_TAPS  = 3'd0,
    REG_SCALE_SHIFT  = 3'd1,
    REG_SUM_OFFSET   = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic row0;      // first row of the frame
    logic row_ge2;   // older row is valid
    logic pix_row;   // request carries a frame pixel
    logic shift;     // window advances
    logic x_ge2;     // left column is inside the row
    logic edge_res;  // right-edge result of the row two back
    logic mid_res;   // regular result
    logic last;      // last result of the frame
  } ctl_t;

  function automatic logic [KW-1:0] taps_reset();
    logic [KW-1:0] v;
    v = '0;
    for (int i = 0; i < c3cb_pkg::NUM_TAPS; i++) begin
      v[i*TAP_BITS +: TAP_BITS] = TAP_BITS'(c3cb_pkg::RST_TAPS[i]);
    end
    return v;
  endfunction

  localparam logic [KW-1:0] TapsRst = taps_reset();

  // Configuration registers
  logic [KW-1:0]                        taps_q;
  logic [c3cb_pkg::SHIFT_W-1:0]         shift_q;
  logic signed [c3cb_pkg::OFFSET_W-1:0] offset_q;
  logic [c3cb_pkg::WIDTH_W-1:0]         fwidth_q;
  logic [c3cb_pkg::HEIGHT_W-1:0]        fheight_q;

  logic     cfg_wr;
  logic     restart;
  reg_idx_e reg_idx;

  logic [WW-1:0] weff;
  logic [HW-1:0] heff;
  logic          w_ge2;

  // Stream position
  logic [AW-1:0] x_q;
  logic [RW-1:0] r_q;
  logic          last_col;
  ctl_t          ctl_d;
  logic          match;

  // Pipeline handshake
  logic free_out, free3, free2, free1;
  logic accept, take, go1;

  // Stage 1
  logic          v1_q;
  ctl_t          ctl1_q;
  logic [PW-1:0] pix1_q;
  logic [AW-1:0] addr1_q;
  logic [2*PW-1:0] lb_rdata;
  logic [PW-1:0] mid_rd, old_rd;
  c3cb_pkg::col_t new_col;
  c3cb_pkg::col_t cell_in  [c3cb_pkg::NUM_CELLS];
  c3cb_pkg::col_t cell_out [c3cb_pkg::NUM_CELLS];
  c3cb_pkg::win_t win_d;

  // Stage 2 and 3
  logic           v2_q, last2_q;
  c3cb_pkg::win_t win2_q;
  logic           v3_q, last3_q;
  logic [PW-1:0]  filt_pix;

  // Output register
  logic          out_valid_q;
  logic [PW-1:0] pix_out_q;
  logic          frame_end_q;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[c3cb_pkg::APB_AW-1:3]);
  assign restart = cfg_wr && (reg_idx == REG_FRAME_WIDTH || reg_idx == REG_FRAME_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q    <= TapsRst;
      shift_q   <= c3cb_pkg::RST_SCALE_SHIFT;
      offset_q  <= c3cb_pkg::RST_SUM_OFFSET;
      fwidth_q  <= c3cb_pkg::RST_FRAME_WIDTH;
      fheight_q <= c3cb_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_KERNEL_TAPS:  taps_q    <= pwdata[KW-1:0];
        REG_SCALE_SHIFT:  shift_q   <= pwdata[c3cb_pkg::SHIFT_W-1:0];
        REG_SUM_OFFSET:   offset_q  <= $signed(pwdata[c3cb_pkg::OFFSET_W-1:0]);
        REG_FRAME_WIDTH:  fwidth_q  <= pwdata[c3cb_pkg::WIDTH_W-1:0];
        REG_FRAME_HEIGHT: fheight_q <= pwdata[c3cb_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      REG_KERNEL_TAPS:  prdata = c3cb_pkg::APB_DW'(taps_q);
      REG_SCALE_SHIFT:  prdata = c3cb_pkg::APB_DW'(shift_q);
      REG_SUM_OFFSET:   prdata = c3cb_pkg::APB_DW'($unsigned(offset_q));
      REG_FRAME_WIDTH:  prdata = c3cb_pkg::APB_DW'(fwidth_q);
      REG_FRAME_HEIGHT: prdata = c3cb_pkg::APB_DW'(fheight_q);
      default:          prdata = '0;
    endcase
  end

  // Effective geometry: zero acts as one, clamp to the maximum
  always_comb begin
    if (fwidth_q == '0) begin
      weff = WW'(1);
    end else if (int'(fwidth_q) > MAX_WIDTH) begin
      weff = WW'(MAX_WIDTH);
    end else begin
      weff = WW'(fwidth_q);
    end
    if (fheight_q == '0) begin
      heff = HW'(1);
    end else if (int'(fheight_q) > MAX_HEIGHT) begin
      heff = HW'(MAX_HEIGHT);
    end else begin
      heff = HW'(fheight_q);
    end
  end

  assign w_ge2 = weff >= WW'(2);

  // ---------------------------------------------------------------- position decode
  always_comb begin
    ctl_d.row0     = (r_q == '0);
    ctl_d.row_ge2  = (r_q >= RW'(2));
    ctl_d.pix_row  = (r_q < RW'(heff));
    ctl_d.shift    = (r_q <= RW'(heff));
    ctl_d.x_ge2    = (x_q >= AW'(2));
    ctl_d.edge_res = (x_q == '0) && ctl_d.row_ge2;
    ctl_d.mid_res  = (x_q != '0) && (r_q != '0) && ctl_d.shift;
    ctl_d.last     = (r_q == RW'(heff) + RW'(1));
  end

  assign last_col = (WW'(x_q) == weff - WW'(1));
  // Early flush or surplus pixel is dropped
  assign match    = (in_ch.flush != ctl_d.pix_row);

  // ---------------------------------------------------------------- handshake chain
  assign free_out = !out_valid_q || out_ch.ready;
  assign free3    = !v3_q || free_out;
  assign free2    = !v2_q || free3;
  assign free1    = !v1_q || free2 || !(ctl1_q.edge_res || ctl1_q.mid_res);
  assign accept   = in_ch.valid && free1;
  assign take     = accept && match;
  assign go1      = v1_q && free1;
  assign in_ch.ready = free1;

  // Stream position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      r_q <= '0;
    end else if (restart) begin
      x_q <= '0;
      r_q <= '0;
    end else if (take) begin
      if (ctl_d.last) begin
        x_q <= '0;
        r_q <= '0;
      end else if (last_col) begin
        x_q <= '0;
        r_q <= r_q + RW'(1);
      end else begin
        x_q <= x_q + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (free1) begin
      v1_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ctl1_q  <= ctl_d;
      pix1_q  <= in_ch.pixel_in;
      addr1_q <= x_q;
    end
  end

  c3cb_linebuf #(
    .DEPTH (MAX_WIDTH)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (take),
    .rd_addr_i (x_q),
    .wr_en_i   (go1 && ctl1_q.pix_row),
    .wr_addr_i (addr1_q),
    .wr_data_i ({mid_rd, pix1_q}),
    .rd_data_o (lb_rdata)
  );

  assign old_rd = lb_rdata[2*PW-1:PW];
  assign mid_rd = lb_rdata[PW-1:0];

  // New window column with top and bottom replicated at the frame edges
  always_comb begin
    if (ctl1_q.row0) begin
      new_col = {pix1_q, pix1_q, pix1_q};
    end else begin
      new_col[0] = ctl1_q.row_ge2 ? old_rd : mid_rd;
      new_col[1] = mid_rd;
      new_col[2] = ctl1_q.pix_row ? pix1_q : mid_rd;
    end
  end

  // Chain of window cells, the rightmost takes the new column
  for (genvar gi = 0; gi < c3cb_pkg::NUM_CELLS; gi++) begin : g_cell
    c3cb_cell u_cell (
      .clk_i (clk_i),
      .en_i  (go1 && ctl1_q.shift),
      .col_i (cell_in[gi]),
      .col_o (cell_out[gi])
    );
    if (gi == c3cb_pkg::NUM_CELLS - 1) begin : g_head
      assign cell_in[gi] = new_col;
    end else begin : g_link
      assign cell_in[gi] = cell_out[gi+1];
    end
  end

  // Window pick: left column replicates at the left edge or narrow frames
  always_comb begin
    if (ctl1_q.edge_res ? w_ge2 : ctl1_q.x_ge2) begin
      win_d[0] = cell_out[0];
    end else begin
      win_d[0] = cell_out[1];
    end
    win_d[1] = cell_out[1];
    win_d[2] = ctl1_q.edge_res ? cell_out[1] : new_col;
  end

  // ---------------------------------------------------------------- stages 2 and 3
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (free2) begin
        v2_q <= v1_q && (ctl1_q.edge_res || ctl1_q.mid_res);
      end
      if (free3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free2) begin
      win2_q  <= win_d;
      last2_q <= ctl1_q.last && ctl1_q.edge_res;
    end
    if (free3) begin
      last3_q <= last2_q;
    end
  end

  c3cb_filter #(
    .TAP_BITS (TAP_BITS)
  ) u_filter (
    .clk_i    (clk_i),
    .en_i     (free3),
    .taps_i   (taps_q),
    .shift_i  (shift_q),
    .offset_i (offset_q),
    .win_i    (win2_q),
    .pixel_o  (filt_pix)
  );

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (free_out) begin
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_out && v3_q) begin
      pix_out_q   <= filt_pix;
      frame_end_q <= last3_q;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.pixel_out = pix_out_q;
  assign out_ch.frame_end = frame_end_q;

  // ---------------------------------------------------------------- assertions
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(x_q) < weff)
    else $error("column counter beyond frame width");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_q <= RW'(heff) + RW'(1))
    else $error("row counter beyond drain position");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && ctl_d.last && !restart |=> (x_q == '0) && (r_q == '0))
    else $error("position not cleared after last result of frame");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> !(ctl1_q.edge_res && ctl1_q.mid_res))
    else $error("request decoded to two results");

endmodule

// ===== design/c3cb_linebuf.sv =====
// Line buffer: older and newer row pixel pairs in one memory, with write forwarding.
module c3cb_linebuf #(
  parameter int DEPTH = c3cb_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr_i,
  input  logic                           wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr_i,
  input  logic [2*c3cb_pkg::PIX_W-1:0]   wr_data_i,
  output logic [2*c3cb_pkg::PIX_W-1:0]   rd_data_o
);

  localparam int DW = 2 * c3cb_pkg::PIX_W;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;
  logic [DW-1:0] fwd_data_q;
  logic          fwd_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // Read and write to the same entry on one edge: hand over the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

// ===== design/c3cb_cell.sv =====
// Window cell: holds one 3-pixel column and takes its neighbor's column on shift.
module c3cb_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  c3cb_pkg::col_t col_i,
  output c3cb_pkg::col_t col_o
);

  c3cb_pkg::col_t col_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ===== design/c3cb_filter.sv =====
// Filter datapath: nine tap products summed into a register, then offset, round and clamp.
module c3cb_filter #(
  parameter int TAP_BITS = c3cb_pkg::DEF_TAP_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic [c3cb_pkg::NUM_TAPS*TAP_BITS-1:0]  taps_i,
  input  logic [c3cb_pkg::SHIFT_W-1:0]            shift_i,
  input  logic signed [c3cb_pkg::OFFSET_W-1:0]    offset_i,
  input  c3cb_pkg::win_t                          win_i,
  output logic [c3cb_pkg::PIX_W-1:0]              pixel_o
);

  localparam int PROD_W = TAP_BITS + c3cb_pkg::PIX_W + 1;
  localparam int SUM_W  = PROD_W + 4;
  localparam int ADD_W  = (SUM_W > c3cb_pkg::OFFSET_W) ? SUM_W : c3cb_pkg::OFFSET_W;
  localparam int T_W    = ADD_W + 2;

  logic signed [PROD_W-1:0] prod [c3cb_pkg::NUM_TAPS];
  logic signed [SUM_W-1:0]  sum_d, sum_q;
  logic signed [T_W-1:0]    rnd, t_val, shifted;

  // Tap times pixel, taps row-major
  always_comb begin
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        prod[dy*3+dx] = $signed(taps_i[(dy*3+dx)*TAP_BITS +: TAP_BITS])
                      * $signed({1'b0, win_i[dx][dy]});
      end
    end
  end

  // Add tree over the nine products
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < c3cb_pkg::NUM_TAPS; i++) begin
      sum_d = sum_d + SUM_W'(prod[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  // Offset, round half up, shift, clamp to 0..255
  always_comb begin
    rnd = '0;
    if (shift_i != '0) begin
      rnd = T_W'(1) << (shift_i - 4'd1);
    end
    t_val   = T_W'(sum_q) + T_W'(offset_i) + rnd;
    shifted = t_val >>> shift_i;
    if (t_val[T_W-1]) begin
      pixel_o = '0;
    end else if (|shifted[T_W-1:c3cb_pkg::PIX_W]) begin
      pixel_o = '1;
    end else begin
      pixel_o = shifted[c3cb_pkg::PIX_W-1:0];
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench of the 3x3 convolution block: streams frames, predicts each filtered pixel, checks it.
module tb_top;
  import c3cb_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int MAXW     = DEF_MAX_WIDTH;
  localparam int MAXH     = DEF_MAX_HEIGHT;
  localparam int TAPW     = DEF_TAP_BITS;
  localparam int TAPS_W   = NUM_TAPS * TAPW;

  // Register indexes; every register sits on an 8-byte stride (taps need 45 bits)
  localparam int REG_TAPS   = 0;
  localparam int REG_SHIFT  = 1;
  localparam int REG_OFFSET = 2;
  localparam int REG_WIDTH  = 3;
  localparam int REG_HEIGHT = 4;
  localparam int REG_STRIDE = 8;

  localparam int IDLE_GAP    = 8;     // pipeline is 4 deep, allow some slack
  localparam int DRAIN_LIMIT = 5000;
  localparam int MAX_REPORTS = 50;
  localparam int RAND_ITEMS  = 1400;
  localparam longint RUN_LIMIT = 64'd1_000_000 * 2 * CLK_HALF;

  typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_e;
  typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_RAMP} pix_kind_e;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             fend;
  } filt_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  c3cb_in_if  in_if ();
  c3cb_out_if out_if ();

  conv3x3_clamped_border i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Shadow of the configuration registers
  logic [TAPS_W-1:0]          cfg_taps;
  logic [SHIFT_W-1:0]         cfg_shift;
  logic signed [OFFSET_W-1:0] cfg_offset;
  logic [WIDTH_W-1:0]         cfg_width;
  logic [HEIGHT_W-1:0]        cfg_height;

  // Predictor state: two line stores, 3x3 window [row][col], stream position
  logic [PIX_W-1:0] line_old [MAXW];
  logic [PIX_W-1:0] line_new [MAXW];
  logic [PIX_W-1:0] win [3][3];
  int               pos_col;
  int               pos_row;

  filt_res_t pix_expect_q [$];

  int         err_cnt;
  int         report_cnt;
  int         items_sent;
  int         burst_left;
  int         hold_left;
  bit         src_gappy;
  sink_mode_e sink_mode;
  logic [7:0] stall_pat;

  function automatic int eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAXW) return MAXW;
    return int'(cfg_width);
  endfunction

  function automatic int eff_height();
    if (cfg_height == 0) return 1;
    if (cfg_height > MAXH) return MAXH;
    return int'(cfg_height);
  endfunction

  function automatic void restart_frame();
    pos_col = 0;
    pos_row = 0;
    foreach (win[a, b]) win[a][b] = '0;
  endfunction

  function automatic bit may_report();
    report_cnt++;
    return report_cnt <= MAX_REPORTS;
  endfunction

  // Weighted window sum with offset, round-half-up shift and saturation
  function automatic logic [PIX_W-1:0] window_sum(int lc, int cc, int rc);
    int     cols [3];
    longint acc;
    int     tap;
    cols = '{lc, cc, rc};
    acc  = 0;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        tap = $signed(cfg_taps[(dy*3+dx)*TAPW +: TAPW]);
        acc += longint'(tap) * longint'(win[dy][cols[dx]]);
      end
    end
    acc += longint'(cfg_offset);
    if (cfg_shift != 0) acc += longint'(1) << (cfg_shift - 1);
    if (acc < 0) return '0;
    acc = acc >>> cfg_shift;
    return (acc > 255) ? PIX_W'(255) : PIX_W'(acc);
  endfunction

  // Advance the predictor by one accepted request and queue any result
  task automatic conv_predict(input logic fl, input logic [PIX_W-1:0] px);
    int               w;
    int               h;
    int               r;
    int               x;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
    bit               last_px;
    filt_res_t        res;
    w = eff_width();
    h = eff_height();
    r = pos_row;
    x = pos_col;
    last_px = 1'b0;
    // early flush or surplus pixel: dropped
    if ((fl == 1'b1) != (r >= h)) return;
    if (x >= w) x = w - 1;

    // right edge of the row two back, taken before the window shifts
    if (x == 0 && r >= 2) begin
      last_px  = (r == h + 1);
      res.pix  = window_sum((w >= 2) ? 1 : 2, 2, 2);
      res.fend = last_px;
      pix_expect_q.push_back(res);
    end

    if (r <= h) begin
      if (r == 0) begin
        top = px;
        mid = px;
        bot = px;
        line_new[x] = px;
      end else begin
        mid = line_new[x];
        top = (r >= 2) ? line_old[x] : mid;
        bot = (r < h) ? px : mid;
        if (r < h) begin
          line_old[x] = mid;
          line_new[x] = px;
        end
      end
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = bot;
      if (x >= 1 && r >= 1) begin
        res.pix  = window_sum((x >= 2) ? 0 : 1, 1, 2);
        res.fend = 1'b0;
        pix_expect_q.push_back(res);
      end
    end

    if (last_px) begin
      restart_frame();
    end else begin
      x++;
      if (x >= w) begin
        x = 0;
        r++;
      end
      pos_col = x;
      pos_row = r;
    end
  endtask

  // Register write: setup phase, access phase, then an idle bus before the shadow registers follow
  task automatic cfg_write(input int idx, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx * REG_STRIDE);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_TAPS:   cfg_taps   = val[TAPS_W-1:0];
      REG_SHIFT:  cfg_shift  = val[SHIFT_W-1:0];
      REG_OFFSET: cfg_offset = val[OFFSET_W-1:0];
      REG_WIDTH: begin
        cfg_width = val[WIDTH_W-1:0];
        restart_frame();
      end
      REG_HEIGHT: begin
        cfg_height = val[HEIGHT_W-1:0];
        restart_frame();
      end
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int w, input int h);
    cfg_write(REG_WIDTH, APB_DW'(w));
    cfg_write(REG_HEIGHT, APB_DW'(h));
  endtask

  task automatic set_filter(input logic [APB_DW-1:0] taps, input int shift, input int offset);
    cfg_write(REG_TAPS, taps);
    cfg_write(REG_SHIFT, APB_DW'(shift));
    cfg_write(REG_OFFSET, APB_DW'(offset));
  endtask

  // Send one request; in gappy mode bursts of random length alternate with gaps
  task automatic send_req(input logic fl, input logic [PIX_W-1:0] px);
    int gap;
    if (src_gappy && burst_left <= 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid    <= 1'b1;
    in_if.flush    <= fl;
    in_if.pixel_in <= px;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    conv_predict(fl, px);
  endtask

  // Stop sending, wait for all predicted pixels, then let the pipeline settle
  task automatic wait_idle();
    int n;
    n = 0;
    in_if.valid <= 1'b0;
    while (pix_expect_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    if (pix_expect_q.size() != 0) begin
      err_cnt++;
      if (may_report())
        $display("%0t: missing result: expected pixel %0d frame_end %0b, actual none (%0d left)",
                 $time, pix_expect_q[0].pix, pix_expect_q[0].fend, pix_expect_q.size());
      pix_expect_q.delete();
    end
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  function automatic logic [PIX_W-1:0] make_pixel(pix_kind_e kind, int idx);
    case (kind)
      PIX_EXTREME: return ($urandom_range(1) != 0) ? PIX_W'(255) : PIX_W'(0);
      PIX_RAMP:    return PIX_W'(idx * 37);
      default:     return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // One frame at the current geometry: pixels, then W+1 flush requests.
  // noise_pct mixes in dropped requests; stop_at >= 0 cuts the frame short.
  task automatic run_frame(input pix_kind_e kind, input int noise_pct, input int stop_at);
    int w;
    int h;
    w = eff_width();
    h = eff_height();
    for (int i = 0; i < w * h; i++) begin
      if (i == stop_at) return;
      if ($urandom_range(99) < noise_pct) send_req(1'b1, PIX_W'($urandom_range(255)));
      send_req(1'b0, make_pixel(kind, i));
      items_sent++;
    end
    for (int i = 0; i <= w; i++) begin
      if ($urandom_range(99) < noise_pct) send_req(1'b0, PIX_W'($urandom_range(255)));
      send_req(1'b1, PIX_W'($urandom_range(255)));
      items_sent++;
    end
  endtask

  // Result side: check each accepted pixel, then drive ready for the next cycle
  task automatic check_result(input logic [PIX_W-1:0] pix, input logic fend);
    filt_res_t want;
    if (pix_expect_q.size() == 0) begin
      err_cnt++;
      if (may_report())
        $display("%0t: unexpected result: expected none, actual pixel %0d frame_end %0b",
                 $time, pix, fend);
      return;
    end
    want = pix_expect_q.pop_front();
    if (pix !== want.pix || fend !== want.fend) begin
      err_cnt++;
      if (may_report())
        $display("%0t: mismatch: expected pixel %0d frame_end %0b, actual pixel %0d frame_end %0b",
                 $time, want.pix, want.fend, pix, fend);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) check_result(out_if.pixel_out, out_if.frame_end);
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      case (sink_mode)
        SINK_ALWAYS: out_if.ready <= 1'b1;
        SINK_RANDOM: out_if.ready <= ($urandom_range(3) != 0);
        default: begin
          out_if.ready <= stall_pat[0];
          stall_pat = {stall_pat[0], stall_pat[7:1]};
        end
      endcase
    end
  end

  // Reset filter on a small frame: dropped requests, extremes, back-to-back frames
  task automatic test_directed();
    logic [PIX_W-1:0] pats [12] = '{8'd0, 8'd255, 8'd0, 8'd255,
                                    8'd255, 8'd0, 8'd255, 8'd0,
                                    8'd128, 8'd1, 8'd254, 8'd127};
    sink_mode = SINK_ALWAYS;
    src_gappy = 1'b0;
    set_geometry(4, 3);
    // flush while pixels are still due: dropped
    send_req(1'b1, 8'hff);
    foreach (pats[i]) send_req(1'b0, pats[i]);
    // pixel while the frame drains: dropped
    send_req(1'b0, 8'h5a);
    repeat (5) send_req(1'b1, 8'h00);
    // a new frame follows the frame end without any register write
    sink_mode = SINK_RANDOM;
    run_frame(PIX_EXTREME, 0, -1);
    wait_idle();
  endtask

  // Saturation at both ends, identity filter, then a few random filters
  task automatic test_filter_extremes();
    logic [APB_DW-1:0] ident;
    ident = APB_DW'(1) << (4 * TAPW);
    src_gappy = 1'b1;
    sink_mode = SINK_RANDOM;
    set_geometry(5, 4);
    set_filter(APB_DW'({NUM_TAPS{5'b01111}}), 0, 65535);
    run_frame(PIX_EXTREME, 0, -1);
    wait_idle();
    set_filter(APB_DW'({NUM_TAPS{5'b10000}}), 15, -65536);
    run_frame(PIX_EXTREME, 0, -1);
    wait_idle();
    set_filter(ident, 0, 0);
    run_frame(PIX_RANDOM, 0, -1);
    wait_idle();
    repeat (3) begin
      set_filter({$urandom, $urandom}, $urandom_range(15), $urandom_range(0, 17'h1ffff));
      sink_mode = sink_mode_e'($urandom_range(2));
      stall_pat = 8'($urandom_range(1, 255));
      run_frame(PIX_RAMP, 0, -1);
      wait_idle();
    end
  endtask

  // Tiny, zero-sized, oversized and restarted frames
  task automatic test_geometry_edges();
    int geo_w [6] = '{0, 1, 7, 2, 3, 1};
    int geo_h [6] = '{0, 5, 1, 2, 1, 1};
    set_filter(APB_DW'(1169376216129), 4, 0);
    src_gappy = 1'b1;
    sink_mode = SINK_RANDOM;
    foreach (geo_w[i]) begin
      set_geometry(geo_w[i], geo_h[i]);
      run_frame(PIX_RANDOM, 0, -1);
      wait_idle();
    end
    // a geometry write in the middle of a frame starts the frame over
    set_geometry(6, 4);
    run_frame(PIX_RANDOM, 0, 9);
    wait_idle();
    cfg_write(REG_HEIGHT, APB_DW'(4));
    run_frame(PIX_RANDOM, 0, -1);
    wait_idle();
    // oversized width and height clamp to the maximum
    src_gappy = 1'b0;
    set_filter({$urandom, $urandom}, 6, 100);
    set_geometry(4095, 2);
    run_frame(PIX_RANDOM, 0, -1);
    wait_idle();
    set_geometry(1, 8191);
    run_frame(PIX_RANDOM, 0, -1);
    wait_idle();
  endtask

  // Long output stall while the input keeps offering requests
  task automatic test_backpressure();
    src_gappy = 1'b0;
    sink_mode = SINK_ALWAYS;
    set_geometry(8, 6);
    hold_left = 250;
    run_frame(PIX_RANDOM, 0, -1);
    wait_idle();
  endtask

  // Random frames: random filters, sizes and traffic, some noise and cut frames
  task automatic test_random_frames();
    int stop;
    int w;
    int h;
    int goal;
    bit cut;
    cut  = 1'b1;
    goal = items_sent + RAND_ITEMS;
    while (items_sent < goal) begin
      if (cut || $urandom_range(1) != 0) begin
        wait_idle();
        if ($urandom_range(1) != 0)
          set_filter({$urandom, $urandom}, $urandom_range(15),
                     ($urandom_range(1) != 0) ? 0 : $urandom_range(0, 17'h1ffff));
        w = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
        h = ($urandom_range(9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 8);
        set_geometry(w, h);
      end
      src_gappy = $urandom_range(1);
      sink_mode = sink_mode_e'($urandom_range(2));
      stall_pat = 8'($urandom_range(1, 255));
      stop = ($urandom_range(9) == 0) ? $urandom_range(0, eff_width() * eff_height() - 1) : -1;
      cut  = (stop >= 0);
      run_frame(pix_kind_e'($urandom_range(2)), 5, stop);
    end
  endtask

  initial begin
    in_if.valid    = 1'b0;
    in_if.flush    = 1'b0;
    in_if.pixel_in = '0;
    out_if.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rst_ni         = 1'b0;
    sink_mode      = SINK_ALWAYS;
    stall_pat      = 8'hff;
    hold_left      = 0;
    src_gappy      = 1'b0;
    burst_left     = 0;
    err_cnt        = 0;
    report_cnt     = 0;
    items_sent     = 0;

    // shadow registers at their reset values
    for (int k = 0; k < NUM_TAPS; k++) cfg_taps[k*TAPW +: TAPW] = TAPW'(RST_TAPS[k]);
    cfg_shift  = RST_SCALE_SHIFT;
    cfg_offset = RST_SUM_OFFSET;
    cfg_width  = RST_FRAME_WIDTH;
    cfg_height = RST_FRAME_HEIGHT;
    foreach (line_old[i]) begin
      line_old[i] = '0;
      line_new[i] = '0;
    end
    restart_frame();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_filter_extremes();
    test_geometry_edges();
    test_backpressure();
    test_random_frames();
    wait_idle();

    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule
